// File: rtl/lcd_fill_rect_byte_stream_top_assert.svh
// ----------------------------------------------------------------------------
// lcd_fill_rect_byte_stream_top_assert.svh
// Assertion macros for the fill-rectangle byte stream block.
// ----------------------------------------------------------------------------
`ifndef LCD_FILL_RECT_BYTE_STREAM_TOP_ASSERT_SVH
`define LCD_FILL_RECT_BYTE_STREAM_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LCDFR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lcdfr: same-cycle check failed");
// next-cycle implication
`define LCDFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lcdfr: next-cycle check failed");
`else
`define LCDFR_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define LCDFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/lcdfr_pkg.sv
// ----------------------------------------------------------------------------
// lcdfr_pkg
// Types and constants for the fill-rectangle byte stream block.
// ----------------------------------------------------------------------------
package lcdfr_pkg;

    localparam int DEF_SCREEN_WIDTH  = 320;
    localparam int DEF_SCREEN_HEIGHT = 240;

    // item opcodes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_PULL  = 1'b1;

    // controller commands
    localparam logic [7:0] OP_COLUMN_SET   = 8'h2A;
    localparam logic [7:0] OP_ROW_SET      = 8'h2B;
    localparam logic [7:0] OP_MEMORY_WRITE = 8'h2C;

    // header sequence positions
    localparam logic [3:0] HS_COL_CMD   = 4'd0;
    localparam logic [3:0] HS_COL_S_HI  = 4'd1;
    localparam logic [3:0] HS_COL_S_LO  = 4'd2;
    localparam logic [3:0] HS_COL_E_HI  = 4'd3;
    localparam logic [3:0] HS_COL_E_LO  = 4'd4;
    localparam logic [3:0] HS_ROW_CMD   = 4'd5;
    localparam logic [3:0] HS_ROW_S_HI  = 4'd6;
    localparam logic [3:0] HS_ROW_S_LO  = 4'd7;
    localparam logic [3:0] HS_ROW_E_HI  = 4'd8;
    localparam logic [3:0] HS_ROW_E_LO  = 4'd9;
    localparam logic [3:0] HS_MEM_CMD   = 4'd10;
    localparam logic [3:0] HS_PIXELS    = 4'd11;

    typedef struct packed {
        logic        cmd;
        logic [15:0] rect_x;
        logic [15:0] rect_y;
        logic [15:0] rect_width;
        logic [15:0] rect_height;
        logic [15:0] fill_color;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_command;
        logic       frame_end;
        logic       last;
    } t_out_item;

endpackage

// File: rtl/lcd_fill_rect_byte_stream_top.sv
// ----------------------------------------------------------------------------
// lcd_fill_rect_byte_stream_top
// Byte stream generator for a fill-rectangle transfer to a serial TFT panel.
//
// A start transfer (cmd = start) loads a rectangle and an RGB565 color; a
// rectangle whose corner lies off-screen is dropped, and width and height
// are clipped to the screen. Each pull transfer (cmd = pull) then yields one
// byte: column-set command, four column address bytes, row-set command, four
// row address bytes, memory-write command, then each pixel as high and low
// color byte. Header bytes each close their own chip-select frame; all pixel
// bytes share one frame that closes after the last pixel. A zero width or
// height sends the header only. A start abandons any running transfer; a
// pull with nothing in progress gives no result, and a start never does.
// Rate: one item per clock. Each item is decoded combinationally against
// the state registers and its byte lands in the output register; the input
// stalls only while that register is full and the sink stalls. The pixel
// count (clipped width times height) goes through one registered multiplier
// the cycle after a start, well before the header's memory-write byte reads
// it.
// ----------------------------------------------------------------------------
module lcd_fill_rect_byte_stream_top #(
    parameter int SCREEN_WIDTH  = lcdfr_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = lcdfr_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  lcdfr_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lcdfr_pkg::t_out_item o_out_item
);
    import lcdfr_pkg::*;

`include "lcd_fill_rect_byte_stream_top_assert.svh"

    // clipped sizes never exceed the screen
    localparam int CW   = $clog2(SCREEN_WIDTH + 1);
    localparam int CH   = $clog2(SCREEN_HEIGHT + 1);
    localparam int PIXW = CW + CH;

    localparam logic [16:0] SW17      = 17'(SCREEN_WIDTH);
    localparam logic [16:0] SH17      = 17'(SCREEN_HEIGHT);
    localparam logic [15:0] COL_LAST  = 16'(SCREEN_WIDTH - 1);
    localparam logic [15:0] ROW_LAST  = 16'(SCREEN_HEIGHT - 1);

    // ---------------- state ----------------
    logic            r_active,     n_active;
    logic [3:0]      r_step,       n_step;
    logic [15:0]     r_col_start,  n_col_start;
    logic [15:0]     r_col_end,    n_col_end;
    logic [15:0]     r_row_start,  n_row_start;
    logic [15:0]     r_row_end,    n_row_end;
    logic [CW-1:0]   r_clip_w,     n_clip_w;
    logic [CH-1:0]   r_clip_h,     n_clip_h;
    logic            r_mul_pend,   n_mul_pend;
    logic [PIXW-1:0] r_pix_left,   n_pix_left;
    logic            r_low_half,   n_low_half;
    logic [15:0]     r_color,      n_color;

    logic            r_out_valid,  n_out_valid;
    t_out_item       r_out,        n_out;

    // ---------------- handshake ----------------
    logic in_xfer;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_xfer     = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // ---------------- start decode: clip ----------------
    logic [16:0] x_end_raw, y_end_raw;
    logic        x_off, y_off, w_clip, h_clip;

    assign x_end_raw = {1'b0, i_in_item.rect_x} + {1'b0, i_in_item.rect_width} - 17'd1;
    assign y_end_raw = {1'b0, i_in_item.rect_y} + {1'b0, i_in_item.rect_height} - 17'd1;
    assign x_off     = {1'b0, i_in_item.rect_x} >= SW17;
    assign y_off     = {1'b0, i_in_item.rect_y} >= SH17;
    assign w_clip    = (i_in_item.rect_width  != 16'd0) && (x_end_raw >= SW17);
    assign h_clip    = (i_in_item.rect_height != 16'd0) && (y_end_raw >= SH17);

    // ---------------- next state ----------------
    always_comb begin
        n_active    = r_active;
        n_step      = r_step;
        n_col_start = r_col_start;
        n_col_end   = r_col_end;
        n_row_start = r_row_start;
        n_row_end   = r_row_end;
        n_clip_w    = r_clip_w;
        n_clip_h    = r_clip_h;
        n_mul_pend  = 1'b0;
        n_pix_left  = r_mul_pend ? PIXW'(r_clip_w * r_clip_h) : r_pix_left;
        n_low_half  = r_low_half;
        n_color     = r_color;
        n_out_valid = r_out_valid & i_out_stall;
        n_out       = r_out;

        if (in_xfer) begin
            if (i_in_item.cmd == CMD_START) begin
                if (x_off || y_off) begin
                    n_active = 1'b0;
                end else begin
                    n_active    = 1'b1;
                    n_step      = HS_COL_CMD;
                    n_low_half  = 1'b0;
                    n_color     = i_in_item.fill_color;
                    n_col_start = i_in_item.rect_x;
                    n_row_start = i_in_item.rect_y;
                    n_col_end   = w_clip ? COL_LAST : x_end_raw[15:0];
                    n_row_end   = h_clip ? ROW_LAST : y_end_raw[15:0];
                    n_clip_w    = w_clip ? CW'(SW17 - {1'b0, i_in_item.rect_x})
                                         : CW'(i_in_item.rect_width);
                    n_clip_h    = h_clip ? CH'(SH17 - {1'b0, i_in_item.rect_y})
                                         : CH'(i_in_item.rect_height);
                    n_mul_pend  = 1'b1;
                end
            end else if (r_active) begin
                if (r_step != HS_PIXELS) begin
                    n_step      = r_step + 4'd1;
                    n_out_valid = 1'b1;
                    n_out.is_command = 1'b0;
                    n_out.frame_end  = 1'b1;
                    n_out.last       = 1'b0;
                    case (r_step)
                        HS_COL_CMD: begin
                            n_out.out_byte   = OP_COLUMN_SET;
                            n_out.is_command = 1'b1;
                        end
                        HS_COL_S_HI: n_out.out_byte = r_col_start[15:8];
                        HS_COL_S_LO: n_out.out_byte = r_col_start[7:0];
                        HS_COL_E_HI: n_out.out_byte = r_col_end[15:8];
                        HS_COL_E_LO: n_out.out_byte = r_col_end[7:0];
                        HS_ROW_CMD: begin
                            n_out.out_byte   = OP_ROW_SET;
                            n_out.is_command = 1'b1;
                        end
                        HS_ROW_S_HI: n_out.out_byte = r_row_start[15:8];
                        HS_ROW_S_LO: n_out.out_byte = r_row_start[7:0];
                        HS_ROW_E_HI: n_out.out_byte = r_row_end[15:8];
                        HS_ROW_E_LO: n_out.out_byte = r_row_end[7:0];
                        default: begin
                            n_out.out_byte   = OP_MEMORY_WRITE;
                            n_out.is_command = 1'b1;
                            if (r_pix_left == '0) begin
                                n_out.last = 1'b1;
                                n_active   = 1'b0;
                            end
                        end
                    endcase
                end else if (r_pix_left == '0) begin
                    n_active = 1'b0;
                end else begin
                    n_out_valid      = 1'b1;
                    n_out.is_command = 1'b0;
                    if (!r_low_half) begin
                        n_out.out_byte  = r_color[15:8];
                        n_out.frame_end = 1'b0;
                        n_out.last      = 1'b0;
                        n_low_half      = 1'b1;
                    end else begin
                        n_out.out_byte  = r_color[7:0];
                        n_low_half      = 1'b0;
                        n_pix_left      = r_pix_left - PIXW'(1);
                        if (r_pix_left == PIXW'(1)) begin
                            n_out.frame_end = 1'b1;
                            n_out.last      = 1'b1;
                            n_active        = 1'b0;
                        end else begin
                            n_out.frame_end = 1'b0;
                            n_out.last      = 1'b0;
                        end
                    end
                end
            end
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_step      <= HS_COL_CMD;
            r_col_start <= '0;
            r_col_end   <= '0;
            r_row_start <= '0;
            r_row_end   <= '0;
            r_clip_w    <= '0;
            r_clip_h    <= '0;
            r_mul_pend  <= 1'b0;
            r_pix_left  <= '0;
            r_low_half  <= 1'b0;
            r_color     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_step      <= n_step;
            r_col_start <= n_col_start;
            r_col_end   <= n_col_end;
            r_row_start <= n_row_start;
            r_row_end   <= n_row_end;
            r_clip_w    <= n_clip_w;
            r_clip_h    <= n_clip_h;
            r_mul_pend  <= n_mul_pend;
            r_pix_left  <= n_pix_left;
            r_low_half  <= n_low_half;
            r_color     <= n_color;
            r_out_valid <= n_out_valid;
        end
    end

    // output payload, no reset
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // ---------------- assertions ----------------
    `LCDFR_ASSERT_SAME(a_low_half_in_pixels, i_clk, i_rst_n, r_low_half, r_step == HS_PIXELS)
    `LCDFR_ASSERT_SAME(a_pixels_nonzero, i_clk, i_rst_n, r_active && (r_step == HS_PIXELS), r_pix_left != '0)
    `LCDFR_ASSERT_NEXT(a_header_yields_byte, i_clk, i_rst_n, in_xfer && (i_in_item.cmd == CMD_PULL) && r_active && (r_step != HS_PIXELS), r_out_valid)

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fill-rectangle byte stream block.
//
// A queue of start and pull transfers is built up front: a short directed
// run over the corner cases, then random rectangles followed by pull bursts
// that either drain the whole stream or abandon it part way. The driver
// feeds the queue into the block and runs a bit-level prediction of the
// byte stream for each accepted transfer. The monitor checks every output
// transfer against the oldest predicted byte. Both sides insert random
// gaps: sender light / receiver heavy, then the reverse, then none.
// ----------------------------------------------------------------------------
module tb;
    import lcdfr_pkg::*;

    localparam int SCR_W        = DEF_SCREEN_WIDTH;
    localparam int SCR_H        = DEF_SCREEN_HEIGHT;
    localparam int N_RANDOM     = 1500;
    localparam int HOLD_CYCLES  = 80;     // long receiver hold-off
    localparam int N_HOLDS      = 3;
    localparam int DRAIN_CYCLES = 20;     // settle time after the last byte
    localparam int STALL_LIMIT  = 2000;   // cycles without any transfer

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    lcd_fill_rect_byte_stream_top #(
        .SCREEN_WIDTH  (SCR_W),
        .SCREEN_HEIGHT (SCR_H)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // stimulus still to be offered, and bytes predicted but not yet seen
    t_in_item  pending_items[$];
    t_out_item expected_bytes[$];

    int n_total     = 0;
    int n_accepted  = 0;
    int n_errors    = 0;
    int holds_done  = 0;
    int hold_left   = 0;
    int idle_cycles = 0;
    bit drain_wait  = 1'b0;

    // ------------------------------------------------------------------------
    // Prediction state: mirrors the block's address window, pixel counter and
    // header position.
    // ------------------------------------------------------------------------
    bit          fill_busy     = 1'b0;
    logic [3:0]  hdr_pos       = HS_COL_CMD;
    logic [15:0] col_first     = '0;
    logic [15:0] col_last      = '0;
    logic [15:0] row_first     = '0;
    logic [15:0] row_last      = '0;
    logic [16:0] pix_remaining = '0;
    bit          low_byte_next = 1'b0;
    logic [15:0] fill_rgb      = '0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Gap rates per phase: first third sender light / receiver heavy, second
    // third the reverse, last third back to back.
    function automatic int send_gap_pct();
        if (n_accepted * 3 < n_total)
            return 11;
        else if (n_accepted * 3 < n_total * 2)
            return 85;
        return 0;
    endfunction

    function automatic int recv_gap_pct();
        if (n_accepted * 3 < n_total)
            return 85;
        else if (n_accepted * 3 < n_total * 2)
            return 11;
        return 0;
    endfunction

    function automatic t_in_item start_item(input int unsigned x, input int unsigned y,
                                            input int unsigned w, input int unsigned h,
                                            input int unsigned rgb);
        t_in_item it;
        it             = '0;
        it.cmd         = CMD_START;
        it.rect_x      = x[15:0];
        it.rect_y      = y[15:0];
        it.rect_width  = w[15:0];
        it.rect_height = h[15:0];
        it.fill_color  = rgb[15:0];
        return it;
    endfunction

    // pull transfers carry random junk in the unused fields
    task automatic queue_pulls(input int n);
        t_in_item it;
        for (int k = 0; k < n; k++) begin
            it             = '0;
            it.cmd         = CMD_PULL;
            it.rect_x      = 16'($urandom);
            it.rect_y      = 16'($urandom);
            it.rect_width  = 16'($urandom);
            it.rect_height = 16'($urandom);
            it.fill_color  = 16'($urandom);
            pending_items.push_back(it);
        end
    endtask

    // ------------------------------------------------------------------------
    // Byte stream prediction for one accepted transfer.
    // ------------------------------------------------------------------------
    task automatic predict_stream(input t_in_item it);
        int unsigned x, y, w, h;
        t_out_item   b;
        bit          emit;
        emit = 1'b0;
        b    = '0;
        if (it.cmd == CMD_START) begin
            x = 32'(it.rect_x);
            y = 32'(it.rect_y);
            w = 32'(it.rect_width);
            h = 32'(it.rect_height);
            if (x >= SCR_W || y >= SCR_H) begin
                // corner off-screen: rectangle dropped, old transfer gone too
                fill_busy = 1'b0;
            end else begin
                if (w != 0 && x + w - 1 >= SCR_W)
                    w = SCR_W - x;
                if (h != 0 && y + h - 1 >= SCR_H)
                    h = SCR_H - y;
                col_first     = x[15:0];
                col_last      = 16'(x + w - 1);  // wraps to 16 bits on zero width at column 0
                row_first     = y[15:0];
                row_last      = 16'(y + h - 1);
                pix_remaining = 17'(w * h);
                fill_rgb      = it.fill_color;
                low_byte_next = 1'b0;
                hdr_pos       = HS_COL_CMD;
                fill_busy     = 1'b1;
            end
        end else if (fill_busy) begin
            if (hdr_pos != HS_PIXELS) begin
                emit        = 1'b1;
                b.frame_end = 1'b1;
                case (hdr_pos)
                    HS_COL_CMD: begin
                        b.out_byte   = OP_COLUMN_SET;
                        b.is_command = 1'b1;
                    end
                    HS_COL_S_HI: b.out_byte = col_first[15:8];
                    HS_COL_S_LO: b.out_byte = col_first[7:0];
                    HS_COL_E_HI: b.out_byte = col_last[15:8];
                    HS_COL_E_LO: b.out_byte = col_last[7:0];
                    HS_ROW_CMD: begin
                        b.out_byte   = OP_ROW_SET;
                        b.is_command = 1'b1;
                    end
                    HS_ROW_S_HI: b.out_byte = row_first[15:8];
                    HS_ROW_S_LO: b.out_byte = row_first[7:0];
                    HS_ROW_E_HI: b.out_byte = row_last[15:8];
                    HS_ROW_E_LO: b.out_byte = row_last[7:0];
                    default: begin
                        b.out_byte   = OP_MEMORY_WRITE;
                        b.is_command = 1'b1;
                        // empty rectangle: header only, ends here
                        if (pix_remaining == 0) begin
                            b.last    = 1'b1;
                            fill_busy = 1'b0;
                        end
                    end
                endcase
                hdr_pos = hdr_pos + 4'd1;
            end else if (pix_remaining == 0) begin
                fill_busy = 1'b0;
            end else if (!low_byte_next) begin
                emit          = 1'b1;
                b.out_byte    = fill_rgb[15:8];
                low_byte_next = 1'b1;
            end else begin
                emit          = 1'b1;
                b.out_byte    = fill_rgb[7:0];
                low_byte_next = 1'b0;
                pix_remaining = pix_remaining - 17'd1;
                if (pix_remaining == 0) begin
                    b.frame_end = 1'b1;
                    b.last      = 1'b1;
                    fill_busy   = 1'b0;
                end
            end
        end
        if (emit)
            expected_bytes.push_back(b);
    endtask

    // ------------------------------------------------------------------------
    // Driver: pops the queue on each accepted transfer. Valid only drops after
    // an acceptance, and a stalled payload is held as is. At two points the
    // sender pauses until every predicted byte has come out.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit       offering;
        bit       next_valid;
        t_in_item next_item;
        if (i_rst_n) begin
            offering = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                predict_stream(pending_items.pop_front());
                n_accepted = n_accepted + 1;
                offering   = 1'b0;
                if (n_accepted == n_total / 2 || n_accepted == (n_total * 5) / 6)
                    drain_wait = 1'b1;
            end
            next_valid = offering;
            next_item  = i_in_item;
            if (!offering) begin
                if (drain_wait && expected_bytes.size() == 0)
                    drain_wait = 1'b0;
                if (pending_items.size() != 0 && !drain_wait &&
                    $urandom_range(0, 99) >= send_gap_pct()) begin
                    next_valid = 1'b1;
                    next_item  = pending_items[0];
                end
            end
            i_in_valid <= next_valid;
            i_in_item  <= next_item;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each output transfer, then picks the next stall. In the
    // back-to-back phase the receiver holds off a few times for a long stretch
    // so the output register fills and the block stalls its input.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        bit        next_stall;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected byte %0h", o_out_item.out_byte);
                    n_errors = n_errors + 1;
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_out_item.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0h, got %0h",
                               want.out_byte, o_out_item.out_byte);
                        n_errors = n_errors + 1;
                    end
                    if (o_out_item.is_command !== want.is_command) begin
                        $error("is_command: expected %0b, got %0b",
                               want.is_command, o_out_item.is_command);
                        n_errors = n_errors + 1;
                    end
                    if (o_out_item.frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0b, got %0b",
                               want.frame_end, o_out_item.frame_end);
                        n_errors = n_errors + 1;
                    end
                    if (o_out_item.last !== want.last) begin
                        $error("last: expected %0b, got %0b",
                               want.last, o_out_item.last);
                        n_errors = n_errors + 1;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left  = hold_left - 1;
                next_stall = 1'b1;
            end else if (holds_done < N_HOLDS &&
                         n_accepted * 100 >= n_total * (70 + 8 * holds_done)) begin
                holds_done = holds_done + 1;
                hold_left  = HOLD_CYCLES - 1;
                next_stall = 1'b1;
            end else begin
                next_stall = $urandom_range(0, 99) < recv_gap_pct();
            end
            i_out_stall <= next_stall;
        end
    end

    // watchdog: no transfer on either side for too long means a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus build, reset and end of run.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned x, y, w, h, cw, ch, span, sel, n_directed;

        // single pixel at the origin, white; full stream down to the last flag
        pending_items.push_back(start_item(0, 0, 1, 1, 'hFFFF));
        queue_pulls(13);
        // corner off-screen in x, then a pull with nothing in progress
        pending_items.push_back(start_item('hFFFF, 0, 5, 5, 'h1234));
        queue_pulls(1);
        // corner off-screen in y
        pending_items.push_back(start_item(0, 'hFFFF, 5, 5, 'h1234));
        // far corner, oversize both ways, clipped to one pixel; abandoned
        pending_items.push_back(start_item(SCR_W - 1, SCR_H - 1, 'hFFFF, 'hFFFF, 0));
        queue_pulls(2);
        // new start mid-transfer, zero width at column 0: end column wraps,
        // header only, then one pull past the end
        pending_items.push_back(start_item(0, 7, 0, 3, 'hA55A));
        queue_pulls(12);
        n_directed = pending_items.size();

        // Random part: mostly well-formed rectangles with a pull burst that
        // either drains the stream (plus up to two pulls past it) or abandons
        // it; the rest is off-screen starts and stray pulls.
        while (pending_items.size() < n_directed + N_RANDOM) begin
            sel = $urandom_range(0, 99);
            if (sel < 6) begin
                if ($urandom_range(0, 1))
                    pending_items.push_back(start_item($urandom_range(SCR_W, 65535),
                        $urandom, $urandom, $urandom, $urandom));
                else
                    pending_items.push_back(start_item($urandom, $urandom_range(SCR_H, 65535),
                        $urandom, $urandom, $urandom));
                queue_pulls($urandom_range(0, 2));
            end else if (sel < 10) begin
                queue_pulls($urandom_range(1, 3));
            end else begin
                // hug the right / bottom edge now and then so clipping ends small
                x = ($urandom_range(0, 4) == 0) ? $urandom_range(SCR_W - 4, SCR_W - 1)
                                                : $urandom_range(0, SCR_W - 1);
                y = ($urandom_range(0, 4) == 0) ? $urandom_range(SCR_H - 4, SCR_H - 1)
                                                : $urandom_range(0, SCR_H - 1);
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 6);
                h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 6);
                cw = (w != 0 && x + w - 1 >= SCR_W) ? SCR_W - x : w;
                ch = (h != 0 && y + h - 1 >= SCR_H) ? SCR_H - y : h;
                span = 11 + 2 * cw * ch;
                if (span > 80 || $urandom_range(0, 9) == 0)
                    span = $urandom_range(1, (span > 80) ? 80 : span);
                else
                    span = span + $urandom_range(0, 2);
                pending_items.push_back(start_item(x, y, w, h, $urandom));
                queue_pulls(span);
            end
        end
        n_total = pending_items.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total || expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_bytes.size() != 0) begin
            $error("%0d predicted bytes never came out", expected_bytes.size());
            n_errors = n_errors + 1;
        end
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
